// File: hw/rtl/scp_pkg.sv
package scp_pkg;

    localparam int SCP_MAX_COEFS = 4;
    localparam int SCP_FRAC_BITS = 16;
    localparam int SCP_WORD_W    = 32;
    localparam int SCP_CFG_IDX_W = 3;

    typedef logic signed [SCP_WORD_W-1:0] t_word;

    // Configuration register indexes.
    localparam logic [SCP_CFG_IDX_W-1:0] REG_ANALOG_ENABLE  = 3'd0;
    localparam logic [SCP_CFG_IDX_W-1:0] REG_CONVERT_OFFSET = 3'd1;
    localparam logic [SCP_CFG_IDX_W-1:0] REG_CONVERT_FACTOR = 3'd2;
    localparam logic [SCP_CFG_IDX_W-1:0] REG_COEF_COUNT     = 3'd3;
    localparam logic [SCP_CFG_IDX_W-1:0] REG_COEF_ZERO      = 3'd4;
    localparam logic [SCP_CFG_IDX_W-1:0] REG_COEF_ONE       = 3'd5;
    localparam logic [SCP_CFG_IDX_W-1:0] REG_COEF_TWO       = 3'd6;
    localparam logic [SCP_CFG_IDX_W-1:0] REG_COEF_THREE     = 3'd7;

    // Clamps a wide signed value to the 32-bit signed range.
    function automatic t_word f_sat(input logic signed [64:0] v);
        t_word r;
        if (v > 65'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -65'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/scp_horner_step.sv
module scp_horner_step
    import scp_pkg::*;
#(
    parameter int FRAC_BITS = SCP_FRAC_BITS
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_word i_volt,
    input  t_word i_acc,
    input  logic  i_active,
    input  t_word i_coef,
    output logic  o_valid,
    input  logic  i_ready,
    output t_word o_volt,
    output t_word o_acc
);

    // Stage A holds the product, stage B the new accumulator.
    logic                 r_vld_a;
    logic                 r_vld_b;
    logic signed [63:0]   r_prod;
    t_word                r_volt_a;
    t_word                r_acc_a;
    logic                 r_act_a;
    t_word                r_volt_b;
    t_word                r_acc_b;
    logic                 rdy_a;
    logic                 rdy_b;
    logic signed [63:0]   prod;
    t_word                n_acc;

    assign rdy_b   = !r_vld_b || i_ready;
    assign rdy_a   = !r_vld_a || rdy_b;
    assign o_ready = rdy_a;
    assign prod    = i_volt * i_acc;

    always_comb begin
        if (r_act_a) begin
            n_acc = f_sat(65'(r_prod >>> FRAC_BITS) + 65'(i_coef));
        end else begin
            n_acc = r_acc_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
        end else begin
            if (rdy_a) begin
                r_vld_a <= i_valid;
            end
            if (rdy_b) begin
                r_vld_b <= r_vld_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_a && i_valid) begin
            r_prod   <= prod;
            r_volt_a <= i_volt;
            r_acc_a  <= i_acc;
            r_act_a  <= i_active;
        end
        if (rdy_b && r_vld_a) begin
            r_volt_b <= r_volt_a;
            r_acc_b  <= n_acc;
        end
    end

    assign o_valid = r_vld_b;
    assign o_volt  = r_volt_b;
    assign o_acc   = r_acc_b;

endmodule

// File: hw/rtl/sensor_calibration_polynomial.sv
// Sensor calibration: converts a raw Q16.16 sample to a voltage and then
// runs a calibration polynomial of up to four coefficients over it.
// Input requests arrive on i_valid/o_ready with i_raw_sample; each one
// yields exactly one result request on o_valid/i_ready carrying o_voltage
// and o_calibrated, in order.
// The sample passes through the capture, offset-subtraction, scale-multiply
// and saturation registers; each Horner step then adds a multiply register
// and an add-and-saturate register. Throughput is one request per cycle
// while i_ready stays high: every stage has its own valid bit and moves
// forward whenever the stage after it is empty or moving.
// When the receiver holds i_ready low, the result stays on the outputs,
// the stages behind it fill up, and o_ready drops only once every stage
// is occupied. Nothing is dropped or repeated across a stall.
// Configuration is a plain write port (i_cfg_wr_en, i_cfg_index,
// i_cfg_data) and must only be written while the pipeline is empty.
// A synchronous reset empties the pipeline and restores the registers:
// conversion off, offset 0, factor 1.0, no polynomial, coefficients 0.
module sensor_calibration_polynomial
    import scp_pkg::*;
#(
    parameter int MAX_COEFS = SCP_MAX_COEFS,
    parameter int FRAC_BITS = SCP_FRAC_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [SCP_CFG_IDX_W-1:0] i_cfg_index,
    input  logic [SCP_WORD_W-1:0]    i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  t_word                    i_raw_sample,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_word                    o_voltage,
    output t_word                    o_calibrated
);

    // Configuration registers.
    logic        r_analog_enable;
    t_word       r_offset;
    t_word       r_factor;
    logic [2:0]  r_coef_count;
    t_word       r_coef [0:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_analog_enable <= 1'b0;
            r_offset        <= '0;
            r_factor        <= 32'sd65536;
            r_coef_count    <= '0;
            r_coef[0]       <= '0;
            r_coef[1]       <= '0;
            r_coef[2]       <= '0;
            r_coef[3]       <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_ANALOG_ENABLE:  r_analog_enable <= i_cfg_data[0];
                REG_CONVERT_OFFSET: r_offset        <= i_cfg_data;
                REG_CONVERT_FACTOR: r_factor        <= i_cfg_data;
                REG_COEF_COUNT:     r_coef_count    <= i_cfg_data[2:0];
                REG_COEF_ZERO:      r_coef[0]       <= i_cfg_data;
                REG_COEF_ONE:       r_coef[1]       <= i_cfg_data;
                REG_COEF_TWO:       r_coef[2]       <= i_cfg_data;
                REG_COEF_THREE:     r_coef[3]       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A count beyond the supported number of coefficients is clamped.
    logic [2:0] coef_used;
    assign coef_used = (r_coef_count > 3'(MAX_COEFS)) ? 3'(MAX_COEFS) : r_coef_count;

    // Conversion pipeline: stage 0 captures the sample, stage 1 forms the
    // saturated difference, stage 2 the scale product, stage 3 the voltage
    // and the starting accumulator for Horner's rule.
    logic               r_vld [0:3];
    logic               rdy   [0:3];
    t_word              r_x0;
    t_word              r_x1;
    t_word              r_x2;
    t_word              r_diff;
    logic signed [63:0] r_prod;
    t_word              r_volt;
    t_word              r_acc;
    logic signed [63:0] scale_prod;
    t_word              n_volt;
    t_word              n_acc;
    logic [1:0]         top_idx;

    // Ready into the Horner chain.
    logic               chain_rdy;

    assign rdy[3]  = !r_vld[3] || chain_rdy;
    assign rdy[2]  = !r_vld[2] || rdy[3];
    assign rdy[1]  = !r_vld[1] || rdy[2];
    assign rdy[0]  = !r_vld[0] || rdy[1];
    assign o_ready = rdy[0];

    assign scale_prod = r_diff * r_factor;
    assign top_idx    = 2'(coef_used - 3'd1);

    always_comb begin
        if (r_analog_enable) begin
            n_volt = f_sat(65'(r_prod >>> FRAC_BITS));
        end else begin
            n_volt = r_x2;
        end
        // With no polynomial the accumulator simply carries the voltage.
        if (coef_used == 3'd0) begin
            n_acc = n_volt;
        end else begin
            n_acc = r_coef[top_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
            r_vld[1] <= 1'b0;
            r_vld[2] <= 1'b0;
            r_vld[3] <= 1'b0;
        end else begin
            if (rdy[0]) r_vld[0] <= i_valid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0] && i_valid) begin
            r_x0 <= i_raw_sample;
        end
        if (rdy[1] && r_vld[0]) begin
            r_x1   <= r_x0;
            r_diff <= f_sat(65'(r_x0) - 65'(r_offset));
        end
        if (rdy[2] && r_vld[1]) begin
            r_x2   <= r_x1;
            r_prod <= scale_prod;
        end
        if (rdy[3] && r_vld[2]) begin
            r_volt <= n_volt;
            r_acc  <= n_acc;
        end
    end

    // Horner chain. Entry 0 is the output of stage 3; step j uses
    // coefficient MAX_COEFS-2-j and only acts when that index lies below
    // the highest coefficient in use, so the last steps always do the work.
    logic  h_vld  [0:MAX_COEFS-1];
    logic  h_rdy  [0:MAX_COEFS-1];
    t_word h_volt [0:MAX_COEFS-1];
    t_word h_acc  [0:MAX_COEFS-1];

    assign h_vld[0]  = r_vld[3];
    assign h_volt[0] = r_volt;
    assign h_acc[0]  = r_acc;
    assign chain_rdy = h_rdy[0];

    for (genvar j = 0; j < MAX_COEFS - 1; j++) begin : g_step
        localparam int K = MAX_COEFS - 2 - j;
        logic step_active;

        assign step_active = coef_used > 3'(K + 1);

        scp_horner_step #(
            .FRAC_BITS (FRAC_BITS)
        ) u_step (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_valid  (h_vld[j]),
            .o_ready  (h_rdy[j]),
            .i_volt   (h_volt[j]),
            .i_acc    (h_acc[j]),
            .i_active (step_active),
            .i_coef   (r_coef[K]),
            .o_valid  (h_vld[j+1]),
            .i_ready  (h_rdy[j+1]),
            .o_volt   (h_volt[j+1]),
            .o_acc    (h_acc[j+1])
        );
    end

    assign h_rdy[MAX_COEFS-1] = i_ready;
    assign o_valid      = h_vld[MAX_COEFS-1];
    assign o_voltage    = h_volt[MAX_COEFS-1];
    assign o_calibrated = h_acc[MAX_COEFS-1];

endmodule

// File: hw/rtl/scp_checker.sv
module scp_checker
    import scp_pkg::*;
(
    input logic  i_clk,
    input logic  i_rst_n,
    input logic  o_ready,
    input logic  o_valid,
    input logic  i_ready,
    input t_word o_voltage,
    input t_word o_calibrated
);

    // A reset cycle empties the whole pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // When the output side is free to move, every stage can move, so the
    // input side must be open.
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid || i_ready) |-> o_ready)
        else $error("input blocked while the pipeline can advance");

    // A stalled result stays in place.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_voltage) && $stable(o_calibrated)))
        else $error("result changed or vanished during a stall");

endmodule

bind sensor_calibration_polynomial scp_checker u_scp_checker (.*);

// File: bench/sensor_calibration_polynomial_tb.sv
module sensor_calibration_polynomial_tb
    import scp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // The pipeline is 4 + 2*(MAX_COEFS-1) stages deep. The drain wait adds
    // margin past that depth before configuration changes and the run's end.
    localparam int PIPE_DEPTH   = 4 + 2 * (SCP_MAX_COEFS - 1);
    localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;
    localparam int RANDOM_ITEMS = 1330;
    localparam int LONG_HOLD    = 64;

    localparam t_word Q_MAX_WORD = 32'sh7fff_ffff;
    localparam t_word Q_MIN_WORD = 32'sh8000_0000;
    localparam t_word Q_ONE      = 32'sh0001_0000;

    typedef logic signed [63:0] t_wide;

    localparam t_wide WIDE_HI = 64'sd2147483647;
    localparam t_wide WIDE_LO = -64'sd2147483648;

    typedef struct packed {
        t_word voltage;
        t_word calibrated;
    } t_result;

    // The receiver cycles through several ready patterns so that stalls
    // land on every pipeline stage, with stretches of full throughput too.
    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_COIN,
        RDY_SPARSE,
        RDY_PERIODIC
    } t_rdy_mode;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_cfg_wr_en  = 1'b0;
    logic [SCP_CFG_IDX_W-1:0] i_cfg_index  = REG_ANALOG_ENABLE;
    logic [SCP_WORD_W-1:0]    i_cfg_data   = '0;
    logic                     i_valid      = 1'b0;
    logic                     o_ready;
    t_word                    i_raw_sample = '0;
    logic                     o_valid;
    logic                     i_ready      = 1'b0;
    t_word                    o_voltage;
    t_word                    o_calibrated;

    sensor_calibration_polynomial i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_raw_sample (i_raw_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_voltage    (o_voltage),
        .o_calibrated (o_calibrated)
    );

    // Shadow copy of the configuration registers. It is only updated while
    // the pipeline is empty, so every request sees the values it ran with.
    logic       cfg_analog = 1'b0;
    t_word      cfg_offset = '0;
    t_word      cfg_factor = Q_ONE;
    logic [2:0] cfg_count  = '0;
    t_word      cfg_coef [SCP_MAX_COEFS] = '{default: '0};

    t_word   sample_backlog  [$];
    t_result expected_results[$];

    int n_offered   = 0;
    int n_accepted  = 0;
    int n_errors    = 0;
    int long_hold_at = 32'h7fff_ffff;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the pipeline hangs or loses a result.
    initial begin
        #2_000_000;
        $display("FAIL sensor_calibration_polynomial");
        $finish;
    end

    // Clamps a wide value to the Q16.16 word range.
    function automatic t_word clamp_q(input t_wide v);
        t_word r;
        if (v > WIDE_HI) begin
            r = Q_MAX_WORD;
        end else if (v < WIDE_LO) begin
            r = Q_MIN_WORD;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Computes the voltage and the calibrated value for one raw sample from
    // the shadow registers. Products are full 64-bit and shifted right
    // arithmetically, which truncates toward minus infinity. The Horner
    // accumulator starts at the highest coefficient in use and saturates
    // after every step. A count above the coefficient limit is clipped to it.
    function automatic t_result calibrate_sample(input t_word raw);
        t_result r;
        t_wide   diff;
        t_wide   prod;
        t_word   acc;
        int      n;
        if (cfg_analog) begin
            diff      = t_wide'(clamp_q(t_wide'(raw) - t_wide'(cfg_offset)));
            prod      = diff * t_wide'(cfg_factor);
            r.voltage = clamp_q(prod >>> SCP_FRAC_BITS);
        end else begin
            r.voltage = raw;
        end
        n = (cfg_count > SCP_MAX_COEFS) ? SCP_MAX_COEFS : int'(cfg_count);
        if (n == 0) begin
            acc = r.voltage;
        end else begin
            acc = cfg_coef[n-1];
            for (int k = n - 2; k >= 0; k--) begin
                prod = t_wide'(r.voltage) * t_wide'(acc);
                acc  = clamp_q(t_wide'(cfg_coef[k]) + (prod >>> SCP_FRAC_BITS));
            end
        end
        r.calibrated = acc;
        return r;
    endfunction

    // Picks a Q16.16 word: the range limits and small values around zero
    // are weighted up, since they carry most of the saturation behavior.
    function automatic t_word pick_word();
        t_word w;
        case ($urandom_range(0, 9))
            0:       w = Q_MAX_WORD;
            1:       w = Q_MIN_WORD;
            2:       w = '0;
            3:       w = $urandom_range(0, 1) ? Q_ONE : -Q_ONE;
            4, 5, 6: w = t_word'(int'($urandom_range(0, 262144)) - 131072);
            default: w = t_word'($urandom());
        endcase
        return w;
    endfunction

    // Raw samples also land close to the offset now and then, so the
    // difference crosses zero while conversion is on.
    function automatic t_word pick_sample();
        t_word w;
        case ($urandom_range(0, 7))
            0:       w = cfg_offset + t_word'(int'($urandom_range(0, 65536)) - 32768);
            1, 2:    w = pick_word();
            3:       w = t_word'(int'($urandom_range(0, 1048576)) - 524288);
            default: w = t_word'($urandom());
        endcase
        return w;
    endfunction

    // Writes one register at the falling edge; the write takes effect at
    // the following rising edge. The shadow copy follows the same masking
    // as the block: one bit for the enable, three bits for the count.
    task automatic write_reg(input logic [SCP_CFG_IDX_W-1:0] idx,
                             input logic [SCP_WORD_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_ANALOG_ENABLE:  cfg_analog  = data[0];
            REG_CONVERT_OFFSET: cfg_offset  = data;
            REG_CONVERT_FACTOR: cfg_factor  = data;
            REG_COEF_COUNT:     cfg_count   = data[2:0];
            REG_COEF_ZERO:      cfg_coef[0] = data;
            REG_COEF_ONE:       cfg_coef[1] = data;
            REG_COEF_TWO:       cfg_coef[2] = data;
            REG_COEF_THREE:     cfg_coef[3] = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [31:0] enable_word, input t_word offset,
                             input t_word factor, input logic [31:0] count_word,
                             input t_word c0, input t_word c1,
                             input t_word c2, input t_word c3);
        write_reg(REG_ANALOG_ENABLE,  enable_word);
        write_reg(REG_CONVERT_OFFSET, offset);
        write_reg(REG_CONVERT_FACTOR, factor);
        write_reg(REG_COEF_COUNT,     count_word);
        write_reg(REG_COEF_ZERO,      c0);
        write_reg(REG_COEF_ONE,       c1);
        write_reg(REG_COEF_TWO,       c2);
        write_reg(REG_COEF_THREE,     c3);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Waits until every queued sample has been accepted and every result
    // has come back, then lets the pipeline settle before the next phase.
    task automatic wait_drained();
        while (sample_backlog.size() != 0 || n_offered != n_accepted ||
               expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Sender. A request, once raised, is held with the same sample until the
    // block accepts it. Between requests the sender works in bursts with
    // random gaps; a gap of zero keeps back-to-back requests going.
    int burst_left = 8;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (n_offered == n_accepted) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
                i_raw_sample <= sample_backlog.pop_front();
                i_valid      <= 1'b1;
                n_offered++;
                burst_left--;
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver. Besides its rotating ready pattern it holds off for a long
    // stretch once a trigger point is reached, and occasionally at random,
    // so the pipeline fills and the block has to drop o_ready.
    t_rdy_mode rdy_mode      = RDY_ALWAYS;
    int        mode_left     = 100;
    int        hold_left     = 0;
    int        rx_cycle      = 0;
    logic      long_hold_done = 1'b0;

    always @(negedge i_clk) begin
        logic next_ready;
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
        end else if (!long_hold_done && n_accepted >= long_hold_at) begin
            long_hold_done = 1'b1;
            hold_left      = LONG_HOLD - 1;
            next_ready     = 1'b0;
        end else if ($urandom_range(0, 599) == 0) begin
            hold_left  = $urandom_range(20, 60);
            next_ready = 1'b0;
        end else begin
            case (rdy_mode)
                RDY_ALWAYS:   next_ready = 1'b1;
                RDY_COIN:     next_ready = 1'($urandom_range(0, 1));
                RDY_SPARSE:   next_ready = ($urandom_range(0, 3) == 0);
                RDY_PERIODIC: next_ready = (rx_cycle % 4 != 0);
                default:      next_ready = 1'b1;
            endcase
        end
        mode_left--;
        if (mode_left <= 0) begin
            mode_left = $urandom_range(20, 300);
            rdy_mode  = t_rdy_mode'($urandom_range(0, 3));
        end
        i_ready <= next_ready;
    end

    // Monitor. An accepted input request is predicted at once, since the
    // shadow registers cannot change while anything is in flight. Each
    // accepted result request is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                expected_results.push_back(calibrate_sample(i_raw_sample));
                n_accepted++;
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result with none expected, voltage %h calibrated %h",
                             $time, o_voltage, o_calibrated);
                    n_errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_voltage !== want.voltage) begin
                        $display("%0t: voltage expected %h actual %h",
                                 $time, want.voltage, o_voltage);
                        n_errors++;
                    end
                    if (o_calibrated !== want.calibrated) begin
                        $display("%0t: calibrated expected %h actual %h",
                                 $time, want.calibrated, o_calibrated);
                        n_errors++;
                    end
                end
            end
        end
    end

    initial begin
        int    random_sent;
        int    phase_len;
        t_word w;
        random_sent = 0;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(negedge i_clk);

        // Reset values: no conversion and no polynomial, so both fields
        // should simply echo the sample, including the range limits.
        sample_backlog.push_back('0);
        sample_backlog.push_back(32'sd1);
        sample_backlog.push_back(-32'sd1);
        sample_backlog.push_back(Q_MAX_WORD);
        sample_backlog.push_back(Q_MIN_WORD);
        sample_backlog.push_back(Q_ONE);
        sample_backlog.push_back(-Q_ONE);
        wait_drained();

        // Extreme offset and factor: for the most negative sample the offset
        // difference, the scaled voltage and every Horner step saturate.
        write_all(32'd1, Q_MAX_WORD, Q_MIN_WORD, 32'd4,
                  Q_MAX_WORD, Q_MAX_WORD, Q_MAX_WORD, Q_MAX_WORD);
        sample_backlog.push_back(Q_MIN_WORD);
        sample_backlog.push_back(Q_MAX_WORD);
        sample_backlog.push_back('0);
        sample_backlog.push_back(-32'sd1);
        wait_drained();

        // A count of seven is clipped to four coefficients. Small values
        // keep the cubic in range; the last sample drives it to the limit.
        write_all(32'hffff_fffd, -Q_ONE, 32'sh0002_0000, 32'hffff_ffff,
                  Q_ONE, -32'sh0000_8000, 32'sh0000_4000, 32'sh0002_0000);
        sample_backlog.push_back('0);
        sample_backlog.push_back(Q_ONE);
        sample_backlog.push_back(-32'sh0002_0000);
        sample_backlog.push_back(Q_MAX_WORD);
        wait_drained();

        // One coefficient: the result is the constant term alone.
        write_all(32'd0, '0, Q_ONE, 32'd1,
                  Q_MIN_WORD, 32'sh0000_0003, '0, '0);
        sample_backlog.push_back(Q_MIN_WORD);
        sample_backlog.push_back(Q_MAX_WORD);
        wait_drained();

        // Two coefficients at the negative limit, conversion on with a
        // small factor that truncates odd products downward.
        write_all(32'd1, 32'sh0000_0001, 32'sh0000_0001, 32'd2,
                  Q_MIN_WORD, Q_MIN_WORD, 32'sh7fff_0000, 32'sh8000_ffff);
        sample_backlog.push_back(-32'sd3);
        sample_backlog.push_back(32'sh0001_8000);
        sample_backlog.push_back(Q_MIN_WORD);
        wait_drained();

        // Random phases, each with a fresh configuration. The upper bits
        // of the enable and count words are random as well. The first phase
        // is long and carries the receiver's long hold-off.
        while (random_sent < RANDOM_ITEMS) begin
            w = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 7) : SCP_MAX_COEFS;
            write_all({31'($urandom()), 1'(($urandom_range(0, 3) != 0))},
                      pick_word(), pick_word(),
                      {$urandom() & 32'hffff_fff8} | 32'(w[2:0]),
                      pick_word(), pick_word(), pick_word(), pick_word());
            phase_len = $urandom_range(20, 70);
            if (random_sent == 0) begin
                phase_len    = 150;
                long_hold_at = n_accepted + 10;
            end
            repeat (phase_len) sample_backlog.push_back(pick_sample());
            random_sent += phase_len;
            wait_drained();
        end

        if (n_errors == 0 && expected_results.size() == 0) begin
            $display("PASS sensor_calibration_polynomial");
        end else begin
            $display("FAIL sensor_calibration_polynomial");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/scp_pkg.sv
hw/rtl/scp_horner_step.sv
hw/rtl/sensor_calibration_polynomial.sv
hw/rtl/scp_checker.sv
bench/sensor_calibration_polynomial_tb.sv
